// ----- design/edge_list_sink_completion_assert.svh -----
// Assertion macros shared by the edge list sink completion RTL.
`ifndef EDGE_LIST_SINK_COMPLETION_ASSERT_SVH
`define EDGE_LIST_SINK_COMPLETION_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define ELSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define ELSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/elsc_pkg.sv -----
// Shared types and constants for the edge list sink completion block.
`timescale 1ns / 1ps
package elsc_pkg;

  localparam int NODE_BITS     = 10;
  localparam int MAX_EDGES_DEF = 32;

  typedef logic [NODE_BITS-1:0] node_t;

  typedef struct packed {
    node_t source_node;
    node_t dest_node;
    logic  has_dest;
    logic  last_edge;
  } in_t;

  typedef struct packed {
    node_t added_node;
    logic  node_valid;
    logic  sources_unique;
    logic  overflow;
    logic  last_result;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_clr;   // clear one bitmap entry of the power-up sweep
    logic load_edge;  // take the edge, store it, read its source bit
    logic mark;       // set the source bit, count the edge
    logic drop;       // edge beyond capacity
    logic idx_zero;   // restart the walk index
    logic rd_dest;    // read a stored destination
    logic rd_map;     // read both bitmaps at that destination
    logic chk;        // act on the lookup, advance the index
    logic flush;      // emit the final result of the run
    logic clr_rd;     // read a stored edge for clearing
    logic clr_wr;     // clear its bitmap bits, advance the index
    logic clr_done;   // reset count and flags for the next list
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_done;
    logic can_store;
    logic last_r;
    logic found;
    logic pend_v;
    logic out_free;
    logic idx_last;
  } dp_stat_t;

endpackage

// ----- design/edge_list_sink_completion.sv -----
// Top level of the edge list sink completion block.
`timescale 1ns / 1ps
// Loads an edge list and, on the edge flagged last, emits every stored destination that
// never appeared as a source, once each and in arrival order, followed by the status flags
// on each result and last_result on the final one (a run with nothing to add yields a
// single result with node_valid low). After reset the two 1024-entry node bitmaps are swept
// clear, one entry per cycle, so no edge is taken until the sweep is done. A stored edge
// takes a source bitmap read, then a mark; an edge beyond MAX_EDGES is dropped. After the
// last edge the replay walks the N stored edges through the edge store and bitmap read
// ports, reading each destination, then both bitmaps, then checking it, and holding while
// the result channel stalls, then emits the final result and clears the bits each edge set.
// Results leave through a register.
module edge_list_sink_completion #(
  parameter int MAX_EDGES = elsc_pkg::MAX_EDGES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  elsc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output elsc_pkg::out_t out_data
);

  elsc_pkg::ctrl_cmd_t cmd;
  elsc_pkg::dp_stat_t  stat;

  elsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_edge),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  elsc_dp #(
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- design/elsc_ctrl.sv -----
// Controller state machine for the edge list sink completion block.
`timescale 1ns / 1ps
module elsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  input  elsc_pkg::dp_stat_t stat,
  output logic               in_stall,
  output elsc_pkg::ctrl_cmd_t cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_MARK  = 4'd2;
  localparam logic [3:0] S_RADDR = 4'd3;
  localparam logic [3:0] S_RMAP  = 4'd4;
  localparam logic [3:0] S_RCHK  = 4'd5;
  localparam logic [3:0] S_FLUSH = 4'd6;
  localparam logic [3:0] S_CADDR = 4'd7;
  localparam logic [3:0] S_CWR   = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_LOAD);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_clr = 1'b1;
        if (stat.init_done) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (in_valid) begin
          if (stat.can_store) begin
            cmd.load_edge = 1'b1;
            state_nxt     = S_MARK;
          end else begin
            cmd.drop = 1'b1;
            if (in_last) begin
              cmd.idx_zero = 1'b1;
              state_nxt    = S_RADDR;
            end
          end
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (stat.last_r) begin
          cmd.idx_zero = 1'b1;
          state_nxt    = S_RADDR;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_RADDR: begin
        cmd.rd_dest = 1'b1;
        state_nxt   = S_RMAP;
      end
      S_RMAP: begin
        cmd.rd_map = 1'b1;
        state_nxt  = S_RCHK;
      end
      S_RCHK: begin
        // hold while a found node would push out a pending one into a full output
        if (!(stat.found && stat.pend_v && !stat.out_free)) begin
          cmd.chk   = 1'b1;
          state_nxt = stat.idx_last ? S_FLUSH : S_RADDR;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush    = 1'b1;
          cmd.idx_zero = 1'b1;
          state_nxt    = S_CADDR;
        end
      end
      S_CADDR: begin
        cmd.clr_rd = 1'b1;
        state_nxt  = S_CWR;
      end
      S_CWR: begin
        cmd.clr_wr = 1'b1;
        if (stat.idx_last) begin
          cmd.clr_done = 1'b1;
          state_nxt    = S_LOAD;
        end else begin
          state_nxt = S_CADDR;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

endmodule

// ----- design/elsc_dp.sv -----
// Datapath of the edge list sink completion block: bitmaps, edge store, output register.
`timescale 1ns / 1ps
`include "edge_list_sink_completion_assert.svh"
module elsc_dp #(
  parameter int MAX_EDGES = elsc_pkg::MAX_EDGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  elsc_pkg::in_t       in_data,
  input  elsc_pkg::ctrl_cmd_t cmd,
  output elsc_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output elsc_pkg::out_t      out_data
);

  localparam int NB    = elsc_pkg::NODE_BITS;
  localparam int NODES = 1 << NB;
  localparam int CNT_W = $clog2(MAX_EDGES + 1);
  localparam int IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  // bitmaps and edge store
  logic            src_map [NODES];
  logic            add_map [NODES];
  logic [NB:0]     dest_mem [MAX_EDGES];
  logic [NB-1:0]   src_mem  [MAX_EDGES];

  logic            src_bit_r, add_bit_r;
  logic [NB:0]     dest_rd_r;
  logic [NB-1:0]   src_rd_r;

  logic [NB-1:0]   init_addr_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;
  logic            dup_r, ovf_r, last_r;
  logic [NB-1:0]   edge_src_r;
  logic [NB-1:0]   pend_r;
  logic            pend_v_r;
  logic            out_valid_r;
  elsc_pkg::out_t  out_r;

  logic [NB-1:0]   node;
  logic            found, out_free;
  logic            sm_we, sm_wd, am_we, am_wd;
  logic [NB-1:0]   sm_wa, am_wa, sm_ra;
  logic [IDX_W-1:0] st_wa;

  assign node     = dest_rd_r[NB-1:0];
  assign found    = dest_rd_r[NB] && !src_bit_r && !add_bit_r;
  assign out_free = !out_valid_r || !out_stall;
  assign st_wa    = count_r[IDX_W-1:0];

  always_comb begin
    stat           = '0;
    stat.init_done = &init_addr_r;
    stat.can_store = (count_r < CNT_W'(MAX_EDGES));
    stat.last_r    = last_r;
    stat.found     = found;
    stat.pend_v    = pend_v_r;
    stat.out_free  = out_free;
    stat.idx_last  = (CNT_W'(idx_r) == count_r - CNT_W'(1));
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // write port selection for the two bitmaps
  always_comb begin
    sm_we = 1'b0;
    sm_wa = init_addr_r;
    sm_wd = 1'b0;
    if (cmd.init_clr) begin
      sm_we = 1'b1;
    end else if (cmd.mark) begin
      sm_we = 1'b1;
      sm_wa = edge_src_r;
      sm_wd = 1'b1;
    end else if (cmd.clr_wr) begin
      sm_we = 1'b1;
      sm_wa = src_rd_r;
    end
  end

  always_comb begin
    am_we = 1'b0;
    am_wa = init_addr_r;
    am_wd = 1'b0;
    if (cmd.init_clr) begin
      am_we = 1'b1;
    end else if (cmd.chk && found) begin
      am_we = 1'b1;
      am_wa = node;
      am_wd = 1'b1;
    end else if (cmd.clr_wr) begin
      am_we = 1'b1;
      am_wa = node;
    end
  end

  assign sm_ra = cmd.load_edge ? in_data.source_node : node;

  always_ff @(posedge clk) begin
    if (sm_we) src_map[sm_wa] <= sm_wd;
    if (cmd.load_edge || cmd.rd_map) src_bit_r <= src_map[sm_ra];
  end

  always_ff @(posedge clk) begin
    if (am_we) add_map[am_wa] <= am_wd;
    if (cmd.rd_map) add_bit_r <= add_map[node];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge) dest_mem[st_wa] <= {in_data.has_dest, in_data.dest_node};
    if (cmd.rd_dest || cmd.clr_rd) dest_rd_r <= dest_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge) src_mem[st_wa] <= in_data.source_node;
    if (cmd.clr_rd) src_rd_r <= src_mem[idx_r];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_edge) begin
      edge_src_r <= in_data.source_node;
      last_r     <= in_data.last_edge;
    end
    if (cmd.chk && found) pend_r <= node;
    if (cmd.chk && found && pend_v_r) begin
      out_r.added_node     <= pend_r;
      out_r.node_valid     <= 1'b1;
      out_r.sources_unique <= !dup_r;
      out_r.overflow       <= ovf_r;
      out_r.last_result    <= 1'b0;
    end else if (cmd.flush) begin
      out_r.added_node     <= pend_v_r ? pend_r : '0;
      out_r.node_valid     <= pend_v_r;
      out_r.sources_unique <= !dup_r;
      out_r.overflow       <= ovf_r;
      out_r.last_result    <= 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_addr_r <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      dup_r       <= 1'b0;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init_clr) init_addr_r <= init_addr_r + NB'(1);
      if (cmd.mark) begin
        count_r <= count_r + CNT_W'(1);
        dup_r   <= dup_r | src_bit_r;
      end
      if (cmd.drop) ovf_r <= 1'b1;
      if (cmd.idx_zero) idx_r <= '0;
      else if (cmd.chk || cmd.clr_wr) idx_r <= idx_r + IDX_W'(1);
      if (cmd.chk && found) pend_v_r <= 1'b1;
      else if (cmd.flush) pend_v_r <= 1'b0;
      if ((cmd.chk && found && pend_v_r) || cmd.flush) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cmd.clr_done) begin
        count_r <= '0;
        dup_r   <= 1'b0;
        ovf_r   <= 1'b0;
      end
    end
  end

  `ELSC_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_EDGES), "edge count past capacity")
  `ELSC_ASSERT_IMPL(a_emit_room, cmd.chk && found && pend_v_r, out_free, "result lost on emit")
  `ELSC_ASSERT_IMPL(a_flush_room, cmd.flush, out_free, "final result lost on flush")
  `ELSC_ASSERT_NEXT(a_load_mark, cmd.load_edge, cmd.mark, "stored edge not marked")

endmodule
